// ----- hw/rtl/ssp_pkg.sv -----
// shared types, field widths and status codes for the sorted set pool
// no dependencies
`default_nettype none

package ssp_pkg;

  localparam int unsigned KeyW          = 56;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned SlotW         = 4;
  localparam int unsigned CountW        = 5;
  localparam int unsigned DefPoolDepth  = 16;

  // operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd2;
  localparam logic [StatusW-1:0] ST_LISTED    = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic            operation;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    out_key;
    logic [SlotW-1:0]   slot;
    logic [CountW-1:0]  element_count;
    logic               last;
  } out_item_t;

  // memory strobes from the sequencer to the node store
  typedef struct packed {
    logic key_rd;
    logic link_rd;
    logic key_wr;
    logic link_wr;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssp_store.sv -----
// node store: key memory, and link memory with per-entry valid bits
// depends on ssp_pkg
`default_nettype none

module ssp_store #(
  parameter int unsigned POOL_DEPTH = ssp_pkg::DefPoolDepth,
  parameter int unsigned IW = $clog2(POOL_DEPTH),
  parameter int unsigned LW = $clog2(POOL_DEPTH + 1)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  ssp_pkg::mem_cmd_t         cmd_i,
  input  wire  [IW-1:0]             rd_addr_i,
  input  wire  [IW-1:0]             wr_addr_i,
  input  wire  [ssp_pkg::KeyW-1:0]  key_wdata_i,
  input  wire  [LW-1:0]             link_wdata_i,
  output logic [ssp_pkg::KeyW-1:0]  key_rdata_o,
  output logic [LW-1:0]             link_rdata_o
);
  import ssp_pkg::*;

  localparam logic [LW-1:0] LinkEnd = {LW{1'b1}};

  logic [KeyW-1:0] key_mem  [POOL_DEPTH];
  logic [LW-1:0]   link_mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] link_vld_q;

  logic [KeyW-1:0] key_rd_q;
  logic [LW-1:0]   link_rd_q;
  logic            link_rd_vld_q;
  logic [IW-1:0]   link_rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) begin
      key_mem[wr_addr_i] <= key_wdata_i;
    end
    if (cmd_i.key_rd) begin
      key_rd_q <= key_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_wr) begin
      link_mem[wr_addr_i] <= link_wdata_i;
    end
    if (cmd_i.link_rd) begin
      link_rd_q      <= link_mem[rd_addr_i];
      link_rd_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q    <= '0;
      link_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.link_wr) begin
        link_vld_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.link_rd) begin
        link_rd_vld_q <= link_vld_q[rd_addr_i];
      end
    end
  end

  // unwritten links read as the descending free chain
  always_comb begin
    if (link_rd_vld_q) begin
      link_rdata_o = link_rd_q;
    end else if (link_rd_addr_q == '0) begin
      link_rdata_o = LinkEnd;
    end else begin
      link_rdata_o = LW'(link_rd_addr_q) - LW'(1);
    end
  end

  assign key_rdata_o = key_rd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_set_pool_insert.sv -----
// top level: sequencer for insert and read-out over the node store
// depends on ssp_pkg and ssp_store
`default_nettype none

// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o  in_item_i  (operation, key)
// out       out  out_valid_o/out_ready_i out_item_o (status, out_key, slot, count, last)
//
// one item at a time; an insert of a new key steps through S_START, a read and
// compare of each node passed (S_WALK, S_CMP), then S_ALLOC, S_LINK1, S_LINK2
// a read-out steps through S_START, then S_RO_RD and S_RO_DATA per listed key
// no clearing pass after reset: unwritten links read as the free chain
// a full output register stalls the sequencer in the state that makes a result,
// while a finished result waits the next item is still taken

module sorted_set_pool_insert #(
  parameter int unsigned POOL_DEPTH = ssp_pkg::DefPoolDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ssp_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ssp_pkg::out_item_t  out_item_o
);
  import ssp_pkg::*;

  localparam int unsigned IW = $clog2(POOL_DEPTH);
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CW = LW;
  localparam logic [LW-1:0] LinkEnd   = {LW{1'b1}};
  localparam logic [LW-1:0] DepthLink = LW'(POOL_DEPTH);
  localparam logic [CW-1:0] DepthCnt  = CW'(POOL_DEPTH);
  localparam logic [CW-1:0] DepthLast = CW'(POOL_DEPTH - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_WALK    = 4'd2;
  localparam logic [3:0] S_CMP     = 4'd3;
  localparam logic [3:0] S_ALLOC   = 4'd4;
  localparam logic [3:0] S_LINK1   = 4'd5;
  localparam logic [3:0] S_LINK2   = 4'd6;
  localparam logic [3:0] S_RO_RD   = 4'd7;
  localparam logic [3:0] S_RO_DATA = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [LW-1:0]   head_q, head_d;
  logic [LW-1:0]   free_q, free_d;
  logic [CW-1:0]   count_q, count_d;
  logic            op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [LW-1:0]   cur_q, cur_d;
  logic [LW-1:0]   prev_q, prev_d;
  logic [CW-1:0]   steps_q, steps_d;
  logic [IW-1:0]   node_q, node_d;

  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  mem_cmd_t        cmd;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic [LW-1:0]   link_wdata;
  logic [KeyW-1:0] key_rdata;
  logic [LW-1:0]   link_rdata;

  logic            out_free;
  logic            emit;
  out_item_t       res;
  logic [CW-1:0]   count_inc;
  logic [63:0]     slot_cur_w, slot_node_w, cnt_w, cnt_inc_w;

  ssp_store #(
    .POOL_DEPTH (POOL_DEPTH),
    .IW         (IW),
    .LW         (LW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .key_wdata_i  (key_q),
    .link_wdata_i (link_wdata),
    .key_rdata_o  (key_rdata),
    .link_rdata_o (link_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign count_inc   = count_q + CW'(1);
  assign slot_cur_w  = 64'(cur_q[IW-1:0]);
  assign slot_node_w = 64'(node_q);
  assign cnt_w       = 64'(count_q);
  assign cnt_inc_w   = 64'(count_inc);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    free_d     = free_q;
    count_d    = count_q;
    op_d       = op_q;
    key_d      = key_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    steps_d    = steps_q;
    node_d     = node_q;
    cmd        = '0;
    rd_addr    = cur_q[IW-1:0];
    wr_addr    = node_q;
    link_wdata = LinkEnd;
    emit       = 1'b0;
    res.status        = ST_FULL;
    res.out_key       = key_q;
    res.slot          = '0;
    res.element_count = cnt_w[CountW-1:0];
    res.last          = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i.operation;
          key_d   = in_item_i.key;
          state_d = S_START;
        end
      end

      S_START: begin
        cur_d   = head_q;
        prev_d  = LinkEnd;
        steps_d = '0;
        if (op_q == OP_INSERT) begin
          // full pool, or an exhausted free list, refuses the key
          if (count_q >= DepthCnt || free_q >= DepthLink) begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            state_d = S_WALK;
          end
        end else if (head_q >= DepthLink) begin
          res.status  = ST_EMPTY;
          res.out_key = '0;
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_RO_RD;
        end
      end

      S_WALK: begin
        if (cur_q < DepthLink) begin
          cmd.key_rd  = 1'b1;
          cmd.link_rd = 1'b1;
          state_d     = S_CMP;
        end else begin
          state_d = S_ALLOC;
        end
      end

      S_CMP: begin
        res.status = ST_DUPLICATE;
        res.slot   = slot_cur_w[SlotW-1:0];
        if (steps_q < DepthCnt && key_rdata < key_q) begin
          prev_d  = cur_q;
          cur_d   = link_rdata;
          steps_d = steps_q + CW'(1);
          state_d = S_WALK;
        end else if (key_rdata == key_q) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_ALLOC;
        end
      end

      S_ALLOC: begin
        // fetch the successor of the free head
        node_d      = free_q[IW-1:0];
        rd_addr     = free_q[IW-1:0];
        cmd.link_rd = 1'b1;
        state_d     = S_LINK1;
      end

      S_LINK1: begin
        free_d      = link_rdata;
        cmd.key_wr  = 1'b1;
        cmd.link_wr = 1'b1;
        wr_addr     = node_q;
        link_wdata  = (cur_q < DepthLink) ? cur_q : LinkEnd;
        state_d     = S_LINK2;
      end

      S_LINK2: begin
        res.status        = ST_INSERTED;
        res.slot          = slot_node_w[SlotW-1:0];
        res.element_count = cnt_inc_w[CountW-1:0];
        wr_addr           = prev_q[IW-1:0];
        link_wdata        = LW'(node_q);
        if (out_free) begin
          emit    = 1'b1;
          count_d = count_inc;
          state_d = S_IDLE;
          if (prev_q < DepthLink) begin
            cmd.link_wr = 1'b1;
          end else begin
            head_d = LW'(node_q);
          end
        end
      end

      S_RO_RD: begin
        cmd.key_rd  = 1'b1;
        cmd.link_rd = 1'b1;
        state_d     = S_RO_DATA;
      end

      S_RO_DATA: begin
        res.status  = ST_LISTED;
        res.out_key = key_rdata;
        res.slot    = slot_cur_w[SlotW-1:0];
        res.last    = (link_rdata >= DepthLink) || (steps_q >= DepthLast);
        if (out_free) begin
          emit    = 1'b1;
          cur_d   = link_rdata;
          steps_d = steps_q + CW'(1);
          state_d = res.last ? S_IDLE : S_RO_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= LinkEnd;
      free_q      <= LW'(POOL_DEPTH - 1);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item payload, no reset
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    node_q  <= node_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
